// File: hdl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except those where reset is high.
`define SALB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SALB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/salb_pkg.sv
// Shared constants and controller/datapath interface types of the suffix array builder.
`timescale 1ns / 1ps
`default_nettype none

package salb_pkg;

   localparam int MAX_LEN     = 64;
   localparam int SYMBOL_BITS = 8;

   localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int OFF_W   = LEN_W + 1;
   localparam int RANK_W  = (SYMBOL_BITS > ADDR_W) ? SYMBOL_BITS : ADDR_W;
   localparam int SKEY_W  = RANK_W + 1;
   localparam int KEY_W   = RANK_W + SKEY_W;

   localparam int SYM_IN_W    = 8;
   localparam int OUT_W       = 6;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   typedef struct packed {
      logic load;
      logic run_end;
      logic round_init;
      logic round_next;
      logic key_wr;
      logic cj_start;
      logic cj_step;
      logic c_wr;
      logic r_chk;
      logic k_ld;
      logic t_rd;
      logic h_clr;
      logic h_inc;
      logic l_wr;
      logic o_ld;
      logic i_clr;
      logic i_inc;
   } cmd_type;

   typedef struct packed {
      logic last_i;
      logic last_j;
      logic round_end;
      logic r_zero;
      logic t_ok;
      logic t_eq;
      logic rsp_taken;
   } sts_type;

endpackage

`default_nettype wire

// File: hdl/salb_ram.sv
// Generic RAM: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module salb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]                           rd_data_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]                           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// File: hdl/salb_ctrl.sv
// Sequencing state machine of the suffix array builder.
`timescale 1ns / 1ps
`default_nettype none

module salb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tlast,
   output logic                  req_tready,
   input  wire salb_pkg::sts_type sts,
   output salb_pkg::cmd_type     cmd
);

   localparam logic [4:0] S_LOAD  = 5'd0;
   localparam logic [4:0] S_K_RD  = 5'd1;
   localparam logic [4:0] S_K_WR  = 5'd2;
   localparam logic [4:0] S_C_I   = 5'd3;
   localparam logic [4:0] S_C_IW  = 5'd4;
   localparam logic [4:0] S_C_J   = 5'd5;
   localparam logic [4:0] S_C_WR  = 5'd6;
   localparam logic [4:0] S_L_I   = 5'd7;
   localparam logic [4:0] S_L_R   = 5'd8;
   localparam logic [4:0] S_L_K   = 5'd9;
   localparam logic [4:0] S_L_T   = 5'd10;
   localparam logic [4:0] S_L_C   = 5'd11;
   localparam logic [4:0] S_L_WR  = 5'd12;
   localparam logic [4:0] S_O_RD  = 5'd13;
   localparam logic [4:0] S_O_LD  = 5'd14;
   localparam logic [4:0] S_O_WT  = 5'd15;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_tready = (state_ff == S_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.round_init = 1'b1;
                  cmd.i_clr      = 1'b1;
                  state_in       = S_K_RD;
               end
            end
         end
         S_K_RD: begin
            state_in = S_K_WR;
         end
         S_K_WR: begin
            cmd.key_wr = 1'b1;
            if (sts.last_i) begin
               cmd.i_clr = 1'b1;
               state_in  = S_C_I;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_K_RD;
            end
         end
         S_C_I: begin
            state_in = S_C_IW;
         end
         S_C_IW: begin
            cmd.cj_start = 1'b1;
            state_in     = S_C_J;
         end
         S_C_J: begin
            cmd.cj_step = 1'b1;
            if (sts.last_j) begin
               state_in = S_C_WR;
            end
         end
         S_C_WR: begin
            cmd.c_wr = 1'b1;
            if (sts.last_i) begin
               cmd.i_clr = 1'b1;
               if (sts.round_end) begin
                  cmd.h_clr = 1'b1;
                  state_in  = S_L_I;
               end else begin
                  cmd.round_next = 1'b1;
                  state_in       = S_K_RD;
               end
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_C_I;
            end
         end
         S_L_I: begin
            state_in = S_L_R;
         end
         S_L_R: begin
            cmd.r_chk = 1'b1;
            if (sts.r_zero) begin
               cmd.h_clr = 1'b1;
               if (sts.last_i) begin
                  cmd.i_clr = 1'b1;
                  state_in  = S_O_RD;
               end else begin
                  cmd.i_inc = 1'b1;
                  state_in  = S_L_I;
               end
            end else begin
               state_in = S_L_K;
            end
         end
         S_L_K: begin
            cmd.k_ld = 1'b1;
            state_in = S_L_T;
         end
         S_L_T: begin
            if (sts.t_ok) begin
               cmd.t_rd = 1'b1;
               state_in = S_L_C;
            end else begin
               state_in = S_L_WR;
            end
         end
         S_L_C: begin
            if (sts.t_eq) begin
               cmd.h_inc = 1'b1;
               state_in  = S_L_T;
            end else begin
               state_in = S_L_WR;
            end
         end
         S_L_WR: begin
            cmd.l_wr = 1'b1;
            if (sts.last_i) begin
               cmd.i_clr = 1'b1;
               state_in  = S_O_RD;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_L_I;
            end
         end
         S_O_RD: begin
            state_in = S_O_LD;
         end
         S_O_LD: begin
            cmd.o_ld = 1'b1;
            state_in = S_O_WT;
         end
         S_O_WT: begin
            if (sts.rsp_taken) begin
               if (sts.last_i) begin
                  cmd.run_end = 1'b1;
                  state_in    = S_LOAD;
               end else begin
                  cmd.i_inc = 1'b1;
                  state_in  = S_O_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/salb_dp.sv
// Datapath of the suffix array builder: stores, counters, key compare and output register.
`timescale 1ns / 1ps
`default_nettype none

module salb_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire salb_pkg::cmd_type                      cmd,
   output salb_pkg::sts_type                           sts,
   input  wire logic [salb_pkg::SYM_IN_W-1:0]          req_symbol,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [salb_pkg::OUT_W-1:0]                  rsp_start,
   output logic [salb_pkg::OUT_W-1:0]                  rsp_lcp,
   output logic                                        rsp_ovf,
   output logic                                        rsp_last
);

   localparam int AW = salb_pkg::ADDR_W;
   localparam int LW = salb_pkg::LEN_W;
   localparam int OW = salb_pkg::OFF_W;
   localparam int RW = salb_pkg::RANK_W;
   localparam int SW = salb_pkg::SKEY_W;
   localparam int KW = salb_pkg::KEY_W;
   localparam int YW = salb_pkg::SYMBOL_BITS;
   localparam int QW = salb_pkg::OUT_W;

   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic [OW-1:0] off_ff, off_in;
   logic          first_ff, first_in;
   logic [KW-1:0] keyi_ff, keyi_in;
   logic [AW-1:0] lt_ff, lt_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] r_ff, r_in;
   logic [AW-1:0] k_ff, k_in;
   logic [LW-1:0] h_ff, h_in;
   logic          ov_ff, ov_in;
   logic [QW-1:0] os_ff, os_in;
   logic [QW-1:0] ol_ff, ol_in;
   logic          oo_ff, oo_in;
   logic          oe_ff, oe_in;

   logic [YW-1:0] text_a, text_b;
   logic [RW-1:0] rank_a, rank_b;
   logic [KW-1:0] key_rdata;
   logic [AW-1:0] order_rdata, inv_rdata, prefix_rdata;

   logic [AW-1:0] nm1;
   logic [OW-1:0] ipo, iph, kph;
   logic          ipo_ok, space_ok;
   logic [RW-1:0] src_i, src_o;
   logic [SW-1:0] skey;
   logic          kj_lt, kj_eq;
   logic [AW-1:0] text_ra, text_rb, key_ra, order_ra, prefix_wa;
   logic          prefix_we;

   assign nm1      = AW'(len_ff - LW'(1));
   assign ipo      = OW'(i_ff) + off_ff;
   assign ipo_ok   = ipo < OW'(len_ff);
   assign iph      = OW'(i_ff) + OW'(h_ff);
   assign kph      = OW'(k_ff) + OW'(h_ff);
   assign space_ok = len_ff < LW'(salb_pkg::MAX_LEN);

   // Round zero ranks are the symbols themselves.
   assign src_i = first_ff ? RW'(text_a) : rank_a;
   assign src_o = first_ff ? RW'(text_b) : rank_b;
   assign skey  = ipo_ok ? (SW'(src_o) + SW'(1)) : '0;

   assign kj_lt = key_rdata < keyi_ff;
   assign kj_eq = key_rdata == keyi_ff;

   assign text_ra   = cmd.t_rd ? AW'(iph) : i_ff;
   assign text_rb   = cmd.t_rd ? AW'(kph) : AW'(ipo);
   assign key_ra    = cmd.cj_start ? '0 : (cmd.cj_step ? AW'(j_ff + AW'(1)) : i_ff);
   assign order_ra  = cmd.r_chk ? AW'(inv_rdata - AW'(1)) : i_ff;
   assign prefix_we = (cmd.r_chk && sts.r_zero) || cmd.l_wr;
   assign prefix_wa = cmd.l_wr ? r_ff : '0;

   assign sts.last_i    = i_ff == nm1;
   assign sts.last_j    = j_ff == nm1;
   assign sts.round_end = ((OW + 1)'(off_ff) << 1) > (OW + 1)'(len_ff);
   assign sts.r_zero    = inv_rdata == '0;
   assign sts.t_ok      = (iph < OW'(len_ff)) && (kph < OW'(len_ff));
   assign sts.t_eq      = text_a == text_b;
   assign sts.rsp_taken = ov_ff && rsp_tready;

   salb_ram #(.WIDTH(YW), .DEPTH(salb_pkg::MAX_LEN)) u_text (
      .clock(clock), .wr_en(cmd.load && space_ok), .wr_addr(AW'(len_ff)),
      .wr_data(YW'(req_symbol)), .rd_addr_a(text_ra), .rd_data_a(text_a),
      .rd_addr_b(text_rb), .rd_data_b(text_b));

   salb_ram #(.WIDTH(RW), .DEPTH(salb_pkg::MAX_LEN)) u_rank (
      .clock(clock), .wr_en(cmd.c_wr), .wr_addr(i_ff), .wr_data(RW'(lt_ff)),
      .rd_addr_a(i_ff), .rd_data_a(rank_a), .rd_addr_b(AW'(ipo)), .rd_data_b(rank_b));

   salb_ram #(.WIDTH(KW), .DEPTH(salb_pkg::MAX_LEN)) u_key (
      .clock(clock), .wr_en(cmd.key_wr), .wr_addr(i_ff), .wr_data({src_i, skey}),
      .rd_addr_a(key_ra), .rd_data_a(key_rdata), .rd_addr_b(key_ra), .rd_data_b());

   salb_ram #(.WIDTH(AW), .DEPTH(salb_pkg::MAX_LEN)) u_order (
      .clock(clock), .wr_en(cmd.c_wr), .wr_addr(pos_ff), .wr_data(i_ff),
      .rd_addr_a(order_ra), .rd_data_a(order_rdata), .rd_addr_b(order_ra), .rd_data_b());

   salb_ram #(.WIDTH(AW), .DEPTH(salb_pkg::MAX_LEN)) u_inverse (
      .clock(clock), .wr_en(cmd.c_wr), .wr_addr(i_ff), .wr_data(pos_ff),
      .rd_addr_a(i_ff), .rd_data_a(inv_rdata), .rd_addr_b(i_ff), .rd_data_b());

   salb_ram #(.WIDTH(AW), .DEPTH(salb_pkg::MAX_LEN)) u_prefix (
      .clock(clock), .wr_en(prefix_we), .wr_addr(prefix_wa),
      .wr_data(cmd.l_wr ? AW'(h_ff) : '0),
      .rd_addr_a(i_ff), .rd_data_a(prefix_rdata), .rd_addr_b(i_ff), .rd_data_b());

   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      off_in   = off_ff;
      first_in = first_ff;
      keyi_in  = keyi_ff;
      lt_in    = lt_ff;
      pos_in   = pos_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      h_in     = h_ff;
      ov_in    = ov_ff;
      os_in    = os_ff;
      ol_in    = ol_ff;
      oo_in    = oo_ff;
      oe_in    = oe_ff;

      if (cmd.load) begin
         if (space_ok) begin
            len_in = len_ff + LW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.run_end) begin
         len_in = '0;
         ovf_in = 1'b0;
      end

      if (cmd.i_clr) begin
         i_in = '0;
      end else if (cmd.i_inc) begin
         i_in = i_ff + AW'(1);
      end

      if (cmd.round_init) begin
         off_in   = OW'(1);
         first_in = 1'b1;
      end else if (cmd.round_next) begin
         off_in   = off_ff << 1;
         first_in = 1'b0;
      end

      if (cmd.cj_start) begin
         keyi_in = key_rdata;
         j_in    = '0;
         lt_in   = '0;
         pos_in  = '0;
      end else if (cmd.cj_step) begin
         // New rank counts strictly smaller keys; the sorted slot also counts
         // equal keys at lower positions.
         j_in   = j_ff + AW'(1);
         lt_in  = lt_ff + AW'(kj_lt);
         pos_in = pos_ff + AW'(kj_lt || (kj_eq && (j_ff < i_ff)));
      end

      if (cmd.r_chk) begin
         r_in = inv_rdata;
      end
      if (cmd.k_ld) begin
         k_in = order_rdata;
      end

      if (cmd.h_clr) begin
         h_in = '0;
      end else if (cmd.h_inc) begin
         h_in = h_ff + LW'(1);
      end else if (cmd.l_wr && (h_ff != '0)) begin
         h_in = h_ff - LW'(1);
      end

      if (cmd.o_ld) begin
         ov_in = 1'b1;
         os_in = QW'(order_rdata);
         ol_in = QW'(prefix_rdata);
         oo_in = ovf_ff;
         oe_in = sts.last_i;
      end else if (sts.rsp_taken) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         ov_ff  <= ov_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      off_ff   <= off_in;
      first_ff <= first_in;
      keyi_ff  <= keyi_in;
      lt_ff    <= lt_in;
      pos_ff   <= pos_in;
      r_ff     <= r_in;
      k_ff     <= k_in;
      h_ff     <= h_in;
      os_ff    <= os_in;
      ol_ff    <= ol_in;
      oo_ff    <= oo_in;
      oe_ff    <= oe_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_start  = os_ff;
   assign rsp_lcp    = ol_ff;
   assign rsp_ovf    = oo_ff;
   assign rsp_last   = oe_ff;

endmodule

`default_nettype wire

// File: hdl/suffix_array_lcp_builder.sv
// Top level of the suffix array and LCP builder: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a text one byte word per cycle on the req channel, keeping up
// to 64 symbols; later symbols are dropped and the overflow flag of the run is
// set. The word with tlast starts the build, and req_tready stays low until the
// last result has been taken. The suffix array is built by prefix doubling: each
// round writes a key (rank, rank at the offset plus one or zero past the end) per
// position, then ranks every position by counting smaller keys over all others,
// one key RAM read per cycle, and there are floor(log2 n)+1 rounds. Kasai's
// LCP pass then extends each common prefix by one matched symbol compare at a
// time, and each result is held on rsp until it is taken before the next one
// is loaded. Results come out in rank order: suffix start and common prefix
// with the previous rank.
module suffix_array_lcp_builder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] symbol
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [5:0] suffix_start, [11:6] common_prefix, zero pad
   output logic             rsp_tuser,   // [0] overflow
   output logic             rsp_tlast
);

`include "assert_macros.svh"

   salb_pkg::cmd_type cmd;
   salb_pkg::sts_type sts;
   logic [salb_pkg::OUT_W-1:0] rsp_start;
   logic [salb_pkg::OUT_W-1:0] rsp_lcp;

   salb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   salb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_symbol (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_start  (rsp_start),
      .rsp_lcp    (rsp_lcp),
      .rsp_ovf    (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = salb_pkg::RSP_TDATA_W'({rsp_lcp, rsp_start});

   // Loading and result delivery never overlap.
   `SALB_ASSERT(a_no_load_during_output, clock, reset, (req_tvalid && req_tready) |-> !rsp_tvalid, "input word taken while a result is pending")
   // The word that ends a text starts the build, so input is held off next.
   `SALB_ASSERT(a_build_holds_input, clock, reset, (req_tvalid && req_tready && req_tlast) |=> !req_tready, "input still open after the final symbol")
   // Once the final result is taken the block is ready for a new text.
   `SALB_ASSERT(a_reopen_after_run, clock, reset, (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready, "input not reopened after the final result")
   // Reset empties the output register.
   `SALB_ASSERT_ALWAYS(a_reset_clears_output, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

`default_nettype wire
